/* rtl/core/ntc_pkg.sv */
// shared types and constants of the node text tokenizer
`default_nettype none

package ntc_pkg;

   localparam longint unsigned DEF_MAX_TEXT_BYTES = 64'd65536;

   // depth of the result queue
   localparam int unsigned RESULT_DEPTH = 4;

   typedef enum logic [3:0] {
      KIND_INT    = 4'd0,
      KIND_FLOAT  = 4'd1,
      KIND_STRING = 4'd2,
      KIND_BITS   = 4'd3,
      KIND_LPAREN = 4'd4,
      KIND_RPAREN = 4'd5,
      KIND_LBRACE = 4'd6,
      KIND_OTHER  = 4'd7,
      KIND_END    = 4'd8
   } token_kind_type;

   typedef struct packed {
      token_kind_type kind;
      logic [15:0]    start;
      logic [15:0]    length;
      logic [31:0]    value;
      logic           last;
   } result_type;

   // up to two results from one byte, slot 0 always filled first
   typedef struct packed {
      logic       push0;
      logic       push1;
      result_type rec0;
      result_type rec1;
   } push_type;

endpackage

`default_nettype wire

/* rtl/core/node_text_tokenizer_classifier.sv */
// top level of the node text tokenizer and token classifier
//
//   channel  direction  beat
//   req_     in         one text byte, zero ends the text
//   rsp_     out        one token: kind, start, length, integer value, last flag
//
// a byte is taken every cycle while req_ready is high; it is held in the byte register,
// then the token state is updated and its zero, one or two results enter a four-deep queue
// results leave one per cycle while rsp_ready is high, so a bracket or zero byte that also
// ends an open token gives two results, one after the other, on the result side
// req_ready drops only while a byte waits and the queue has no room for two results
// synchronous reset clears the token state, the byte valid flag and the queue

`default_nettype none

module node_text_tokenizer_classifier #(
   parameter longint unsigned MAX_TEXT_BYTES = ntc_pkg::DEF_MAX_TEXT_BYTES
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_text_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [3:0]       rsp_token_kind,
   output logic [15:0]      rsp_token_start,
   output logic [15:0]      rsp_token_length,
   output logic signed [31:0] rsp_int_value,
   output logic             rsp_last_of_run
);
   import ntc_pkg::*;

   push_type   push;
   logic       room;
   result_type rsp_rec;

   ntc_scan #(
      .MAX_TEXT_BYTES (MAX_TEXT_BYTES)
   ) u_scan (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_text_byte (req_text_byte),
      .room          (room),
      .push          (push)
   );

   ntc_result_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_rec   (rsp_rec)
   );

   assign rsp_token_kind   = rsp_rec.kind;
   assign rsp_token_start  = rsp_rec.start;
   assign rsp_token_length = rsp_rec.length;
   assign rsp_int_value    = signed'(rsp_rec.value);
   assign rsp_last_of_run  = rsp_rec.last;

endmodule

`default_nettype wire

/* rtl/core/ntc_scan.sv */
// byte register, token state and classification of finished tokens
`default_nettype none

module ntc_scan #(
   parameter longint unsigned MAX_TEXT_BYTES = ntc_pkg::DEF_MAX_TEXT_BYTES
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [7:0]       req_text_byte,
   input  wire logic             room,
   output ntc_pkg::push_type     push
);
   import ntc_pkg::*;

   localparam logic [15:0] POS_CAP = ((MAX_TEXT_BYTES - 64'd1) > 64'd65535) ?
                                     16'hFFFF : 16'(MAX_TEXT_BYTES - 64'd1);

   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_NL      = 8'h0A;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_LPAREN  = 8'h28;
   localparam logic [7:0] CHAR_RPAREN  = 8'h29;
   localparam logic [7:0] CHAR_LBRACE  = 8'h7B;
   localparam logic [7:0] CHAR_RBRACE  = 8'h7D;
   localparam logic [7:0] CHAR_BSLASH  = 8'h5C;
   localparam logic [7:0] CHAR_LT      = 8'h3C;
   localparam logic [7:0] CHAR_GT      = 8'h3E;
   localparam logic [7:0] CHAR_B       = 8'h62;
   localparam logic [7:0] CHAR_QUOTE   = 8'h22;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_DOT     = 8'h2E;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [31:0] LIMIT_MAG   = 32'h8000_0000;

   typedef struct packed {
      logic [15:0] start;
      logic [15:0] length;
      logic [7:0]  first;
      logic [7:0]  second;
      logic [7:0]  third;
      logic [7:0]  final_ch;
      logic [31:0] mag;
      logic        neg;
      logic        digits_only;
      logic        too_large;
   } tok_type;

   localparam tok_type TOK_CLEAR = '{start: 16'd0, length: 16'd0, first: 8'd0,
                                     second: 8'd0, third: 8'd0, final_ch: 8'd0,
                                     mag: 32'd0, neg: 1'b0, digits_only: 1'b1,
                                     too_large: 1'b0};

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

   function automatic tok_type add_byte(input tok_type t, input logic [7:0] c);
      tok_type     r;
      logic [35:0] m;
      r = t;
      m = ({4'd0, t.mag} << 3) + ({4'd0, t.mag} << 1) + {32'd0, c[3:0]};
      if (t.length == 16'd0) begin
         r.first = c;
      end else if (t.length == 16'd1) begin
         r.second = c;
      end else if (t.length == 16'd2) begin
         r.third = c;
      end
      r.final_ch = c;
      if ((t.length == 16'd0) && ((c == CHAR_PLUS) || (c == CHAR_MINUS))) begin
         r.neg = (c == CHAR_MINUS);
      end else if (is_digit(c)) begin
         // accumulation stops at 2^31
         if (m > {4'd0, LIMIT_MAG}) begin
            r.mag       = LIMIT_MAG;
            r.too_large = 1'b1;
         end else begin
            r.mag = m[31:0];
         end
      end else begin
         r.digits_only = 1'b0;
      end
      if (t.length != 16'hFFFF) begin
         r.length = t.length + 16'd1;
      end
      return r;
   endfunction

   function automatic result_type classify(input tok_type t, input logic last);
      logic       sign;
      logic [7:0] c0;
      logic [7:0] c1;
      logic [15:0] n;
      logic       numeric;
      logic       fits;
      result_type r;
      sign    = (t.first == CHAR_PLUS) || (t.first == CHAR_MINUS);
      c0      = sign ? t.second : t.first;
      c1      = sign ? t.third : t.second;
      n       = sign ? (t.length - 16'd1) : t.length;
      numeric = ((n > 16'd0) && is_digit(c0)) ||
                ((n > 16'd1) && (c0 == CHAR_DOT) && is_digit(c1));
      fits    = t.neg ? (t.mag <= LIMIT_MAG) : (t.mag < LIMIT_MAG);
      r.kind   = KIND_OTHER;
      r.start  = t.start;
      r.length = t.length;
      r.value  = 32'd0;
      r.last   = last;
      if (numeric) begin
         if (t.digits_only && !t.too_large && fits) begin
            r.kind  = KIND_INT;
            r.value = t.neg ? (32'd0 - t.mag) : t.mag;
         end else begin
            r.kind = KIND_FLOAT;
         end
      end else if (t.first == CHAR_LPAREN) begin
         r.kind = KIND_LPAREN;
      end else if (t.first == CHAR_RPAREN) begin
         r.kind = KIND_RPAREN;
      end else if (t.first == CHAR_LBRACE) begin
         r.kind = KIND_LBRACE;
      end else if ((t.first == CHAR_QUOTE) && (t.length > 16'd1) &&
                   (t.final_ch == CHAR_QUOTE)) begin
         r.kind = KIND_STRING;
      end else if (t.first == CHAR_B) begin
         r.kind = KIND_BITS;
      end
      // the empty token <> reports no length
      if ((t.length == 16'd2) && (t.first == CHAR_LT) && (t.second == CHAR_GT)) begin
         r.length = 16'd0;
      end
      return r;
   endfunction

   logic        byte_vld_ff, byte_vld_in;
   logic [7:0]  byte_ff, byte_in;
   logic        in_tok_ff, in_tok_in;
   logic        esc_ff, esc_in;
   logic [15:0] pos_ff, pos_in;
   tok_type     tok_ff, tok_in;

   logic        fire;
   logic        is_space;
   logic        is_single;
   tok_type     tok_base;
   result_type  fin_rec;
   result_type  fin_mid_rec;
   result_type  single_rec;
   result_type  end_rec;

   assign fire      = byte_vld_ff && room;
   assign req_ready = !byte_vld_ff || room;

   always_comb begin
      byte_vld_in = byte_vld_ff;
      byte_in     = byte_ff;
      if (req_valid && req_ready) begin
         byte_vld_in = 1'b1;
         byte_in     = req_text_byte;
      end else if (fire) begin
         byte_vld_in = 1'b0;
      end
   end

   always_comb begin
      is_space  = (byte_ff == CHAR_SPACE) || (byte_ff == CHAR_NL) ||
                  (byte_ff == CHAR_TAB);
      is_single = (byte_ff == CHAR_LPAREN) || (byte_ff == CHAR_RPAREN) ||
                  (byte_ff == CHAR_LBRACE) || (byte_ff == CHAR_RBRACE);

      tok_base = tok_ff;
      if (!in_tok_ff) begin
         tok_base       = TOK_CLEAR;
         tok_base.start = pos_ff;
      end

      fin_rec     = classify(tok_ff, 1'b1);
      fin_mid_rec = classify(tok_ff, 1'b0);

      single_rec.start  = pos_ff;
      single_rec.length = 16'd1;
      single_rec.value  = 32'd0;
      single_rec.last   = 1'b1;
      case (byte_ff)
         CHAR_LPAREN: single_rec.kind = KIND_LPAREN;
         CHAR_RPAREN: single_rec.kind = KIND_RPAREN;
         CHAR_LBRACE: single_rec.kind = KIND_LBRACE;
         default:     single_rec.kind = KIND_OTHER;
      endcase

      end_rec.kind   = KIND_END;
      end_rec.start  = pos_ff;
      end_rec.length = 16'd0;
      end_rec.value  = 32'd0;
      end_rec.last   = 1'b1;

      tok_in     = tok_ff;
      in_tok_in  = in_tok_ff;
      esc_in     = esc_ff;
      pos_in     = pos_ff;
      push.push0 = 1'b0;
      push.push1 = 1'b0;
      push.rec0  = fin_mid_rec;
      push.rec1  = single_rec;

      if (fire) begin
         pos_in = (pos_ff < POS_CAP) ? (pos_ff + 16'd1) : pos_ff;
         if (byte_ff == 8'd0) begin
            // end of text: flush, report end, start over at offset zero
            push.push0 = 1'b1;
            if (in_tok_ff) begin
               push.push1 = 1'b1;
               push.rec1  = end_rec;
            end else begin
               push.rec0 = end_rec;
            end
            tok_in    = TOK_CLEAR;
            in_tok_in = 1'b0;
            esc_in    = 1'b0;
            pos_in    = 16'd0;
         end else if (in_tok_ff && esc_ff) begin
            tok_in = add_byte(tok_ff, byte_ff);
            esc_in = 1'b0;
         end else if (is_space) begin
            if (in_tok_ff) begin
               push.push0 = 1'b1;
               push.rec0  = fin_rec;
            end
            tok_in    = TOK_CLEAR;
            in_tok_in = 1'b0;
            esc_in    = 1'b0;
         end else if (is_single) begin
            push.push0 = 1'b1;
            if (in_tok_ff) begin
               push.push1 = 1'b1;
            end else begin
               push.rec0 = single_rec;
            end
            tok_in    = TOK_CLEAR;
            in_tok_in = 1'b0;
            esc_in    = 1'b0;
         end else begin
            tok_in    = add_byte(tok_base, byte_ff);
            in_tok_in = 1'b1;
            esc_in    = (byte_ff == CHAR_BSLASH);
         end
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      if (reset) begin
         byte_vld_ff <= 1'b0;
         in_tok_ff   <= 1'b0;
         esc_ff      <= 1'b0;
         pos_ff      <= 16'd0;
         tok_ff      <= TOK_CLEAR;
      end else begin
         byte_vld_ff <= byte_vld_in;
         in_tok_ff   <= in_tok_in;
         esc_ff      <= esc_in;
         pos_ff      <= pos_in;
         tok_ff      <= tok_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/ntc_result_fifo.sv */
// result queue taking up to two results a cycle and giving one while rsp_ready is high
`default_nettype none

module ntc_result_fifo (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ntc_pkg::push_type  push,
   output logic                    room,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output ntc_pkg::result_type     rsp_rec
);
   import ntc_pkg::*;

   localparam int unsigned PTR_W = $clog2(RESULT_DEPTH);
   localparam int unsigned CNT_W = $clog2(RESULT_DEPTH + 1);

   result_type         mem_ff [RESULT_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               pop;
   logic [CNT_W-1:0]   n_push;
   logic [PTR_W-1:0]   wr_ptr_next;

   // room for the two results one byte may cause
   assign room        = count_ff <= CNT_W'(RESULT_DEPTH - 2);
   assign rsp_valid   = count_ff != '0;
   assign rsp_rec     = mem_ff[rd_ptr_ff];
   assign pop         = rsp_valid && rsp_ready;
   assign n_push      = CNT_W'(push.push0) + CNT_W'(push.push1);
   assign wr_ptr_next = wr_ptr_ff + PTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(n_push);
      rd_ptr_in = pop ? (rd_ptr_ff + PTR_W'(1)) : rd_ptr_ff;
      count_in  = count_ff + n_push - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.push0) begin
         mem_ff[wr_ptr_ff] <= push.rec0;
      end
      if (push.push1) begin
         mem_ff[wr_ptr_next] <= push.rec1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/ntc_check.sv */
// port checker for the node text tokenizer, bound to the top level
`default_nettype none

module ntc_check (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic [3:0]         rsp_token_kind,
   input wire logic [15:0]        rsp_token_start,
   input wire logic [15:0]        rsp_token_length,
   input wire logic signed [31:0] rsp_int_value,
   input wire logic               rsp_last_of_run
);
   import ntc_pkg::*;

   // a stalled result beat holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_token_kind) &&
      $stable(rsp_token_start) && $stable(rsp_token_length) &&
      $stable(rsp_int_value) && $stable(rsp_last_of_run))
      else $error("result beat changed while stalled");

   // nothing comes out in the cycle after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_end_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_token_kind == KIND_END) |->
      (rsp_token_length == 16'd0) && rsp_last_of_run && (rsp_int_value == 32'sd0))
      else $error("end of text beat malformed");

   a_value_int_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_token_kind != KIND_INT) |-> rsp_int_value == 32'sd0)
      else $error("value on a token that is not an integer");

   // bracket tokens are always a single byte
   a_bracket_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_token_kind == KIND_LPAREN) || (rsp_token_kind == KIND_RPAREN) ||
      (rsp_token_kind == KIND_LBRACE)) |-> rsp_token_length == 16'd1)
      else $error("bracket token with length other than one");

endmodule

bind node_text_tokenizer_classifier ntc_check u_ntc_check (.*);

`default_nettype wire
